FILE: rtl/core/stis_pkg.sv
// shared types and command codes for the sorted table search block
package stis_pkg;

  localparam int unsigned POS_W = 12;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned CFG_W = 13;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_START,
    OP_SCAN,
    OP_LADDR,
    OP_LCMP,
    OP_RB,
    OP_RE,
    OP_HI,
    OP_MUL,
    OP_DINIT,
    OP_DIV,
    OP_PROBE,
    OP_PK,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic lin;
    logic nzero;
    logic scan_done;
    logic small_ok;
    logic cont;
    logic div_done;
    logic pk_eq;
  } status_t;

endpackage

FILE: rtl/core/stis_ram.sv
// generic single write port ram with registered read
module stis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/stis_datapath.sv
// datapath: key table, search bounds, multiplier, divider and result register
module stis_datapath
  import stis_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = 4096,
  parameter int unsigned LINEAR_LIMIT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  op_t              op,
  output status_t          st,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic [POS_W-1:0] in_pos,
  input  logic [KEY_W-1:0] in_key,
  output logic             res_found,
  output logic [POS_W-1:0] res_pos
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned CW = $clog2(AW + 1);
  localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);
  localparam logic [CW-1:0] DIV_LAST = CW'(AW - 1);

  logic [CFG_W-1:0]      cfg_r;
  logic [KEY_W-1:0]      key_r, lo_r, hi_r, den_r, rem_r;
  logic [NW-1:0]         n_r, idx_r, smaller_r;
  logic                  pend_r;
  logic [AW-1:0]         beg_r, probe_r, q_r;
  logic signed [NW-1:0]  end_r;
  logic [KEY_W+AW-1:0]   num_r;
  logic [CW-1:0]         cnt_r;
  logic                  found_r, out_found_r;
  logic [AW-1:0]         pos_r;
  logic [POS_W-1:0]      out_pos_r;

  logic [KEY_W-1:0] rd;
  logic [AW-1:0]    raddr, waddr, probe_sum, diff;
  logic [31:0]      pos32, res32;
  logic             we;
  logic [NW-1:0]    ncap;
  logic [KEY_W:0]   trial;
  logic [KEY_W:0]   trial_sub;
  logic [AW:0]      q_shift;

  assign pos32     = 32'(in_pos);
  assign waddr     = pos32[AW-1:0];
  assign we        = (op == OP_WRITE) && (pos32 < 32'(TABLE_DEPTH));
  assign probe_sum = beg_r + q_r;
  assign diff      = end_r[AW-1:0] - beg_r;
  assign ncap      = (32'(cfg_r) > 32'(TABLE_DEPTH)) ? DEPTH_N : NW'(cfg_r);
  assign trial     = {rem_r, q_r[AW-1]};
  assign trial_sub = trial - {1'b0, den_r};

  always_comb begin
    case (op)
      OP_SCAN:  raddr = idx_r[AW-1:0];
      OP_LADDR: raddr = smaller_r[AW-1:0];
      OP_RB:    raddr = beg_r;
      OP_RE:    raddr = end_r[AW-1:0];
      OP_PROBE: raddr = probe_sum;
      default:  raddr = '0;
    endcase
  end

  stis_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_key),
    .raddr (raddr),
    .rdata (rd)
  );

  always_comb begin
    st.lin       = 32'(n_r) < 32'(LINEAR_LIMIT);
    st.nzero     = (n_r == '0);
    st.scan_done = (idx_r == n_r) && !pend_r;
    st.small_ok  = smaller_r < n_r;
    st.cont      = ($signed({1'b0, beg_r}) < end_r) && (lo_r <= key_r) && (key_r < rd);
    st.div_done  = (cnt_r == DIV_LAST);
    st.pk_eq     = (rd == key_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_START: begin
        key_r     <= in_key;
        n_r       <= ncap;
        idx_r     <= '0;
        pend_r    <= 1'b0;
        smaller_r <= '0;
        beg_r     <= '0;
        end_r     <= $signed(ncap) - NW'(1);
        found_r   <= 1'b0;
        pos_r     <= '0;
      end
      OP_SCAN: begin
        if (idx_r < n_r) begin
          idx_r  <= idx_r + NW'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
        if (pend_r && (rd < key_r)) begin
          smaller_r <= smaller_r + NW'(1);
        end
      end
      OP_LCMP: begin
        if (rd == key_r) begin
          found_r <= 1'b1;
          pos_r   <= smaller_r[AW-1:0];
        end
      end
      OP_RE: lo_r <= rd;
      OP_HI: begin
        hi_r <= rd;
        if (!st.cont && !end_r[NW-1] && (rd == key_r)) begin
          found_r <= 1'b1;
          pos_r   <= end_r[AW-1:0];
        end
      end
      OP_MUL: begin
        num_r <= {{AW{1'b0}}, key_r - lo_r} * {{KEY_W{1'b0}}, diff};
        den_r <= hi_r - lo_r;
      end
      OP_DINIT: begin
        rem_r <= num_r[KEY_W+AW-1:AW];
        q_r   <= num_r[AW-1:0];
        cnt_r <= '0;
      end
      OP_DIV: begin
        cnt_r <= cnt_r + CW'(1);
        if (!trial_sub[KEY_W]) begin
          rem_r <= trial_sub[KEY_W-1:0];
          q_r   <= q_shift[AW-1:0] | AW'(1);
        end else begin
          rem_r <= trial[KEY_W-1:0];
          q_r   <= q_shift[AW-1:0];
        end
      end
      OP_PROBE: probe_r <= probe_sum;
      OP_PK: begin
        if (rd < key_r) begin
          beg_r <= probe_r + AW'(1);
        end else if (rd > key_r) begin
          end_r <= $signed({1'b0, probe_r}) - NW'(1);
        end else begin
          found_r <= 1'b1;
          pos_r   <= probe_r;
        end
      end
      OP_OUT: begin
        out_found_r <= found_r;
        out_pos_r   <= res32[POS_W-1:0];
      end
      default: ;
    endcase
  end

  assign q_shift   = {q_r, 1'b0};
  assign res32     = 32'(pos_r);
  assign res_found = out_found_r;
  assign res_pos   = out_pos_r;

endmodule

FILE: rtl/core/stis_ctrl.sv
// controller: sequences table writes, scan lookups and interpolation rounds
module stis_ctrl
  import stis_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_action,
  output logic    in_tready,
  input  logic    out_tready,
  output logic    out_tvalid,
  input  status_t st,
  output op_t     op
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SCAN, S_LADDR, S_LCMP, S_RB, S_RE, S_HI,
    S_MUL, S_DINIT, S_DIV, S_PROBE, S_PK, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt      = state_r;
    op             = OP_NONE;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_action == ACT_WRITE) begin
            op = OP_WRITE;
          end else begin
            op        = OP_START;
            state_nxt = S_DISP;
          end
        end
      end
      S_DISP: begin
        if (st.nzero)    state_nxt = S_FIN;
        else if (st.lin) state_nxt = S_SCAN;
        else             state_nxt = S_RB;
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (st.scan_done) begin
          state_nxt = st.small_ok ? S_LADDR : S_FIN;
        end
      end
      S_LADDR: begin
        op        = OP_LADDR;
        state_nxt = S_LCMP;
      end
      S_LCMP: begin
        op        = OP_LCMP;
        state_nxt = S_FIN;
      end
      S_RB: begin
        op        = OP_RB;
        state_nxt = S_RE;
      end
      S_RE: begin
        op        = OP_RE;
        state_nxt = S_HI;
      end
      S_HI: begin
        op        = OP_HI;
        state_nxt = st.cont ? S_MUL : S_FIN;
      end
      S_MUL: begin
        op        = OP_MUL;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        op        = OP_DINIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        op = OP_DIV;
        if (st.div_done) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        op        = OP_PROBE;
        state_nxt = S_PK;
      end
      S_PK: begin
        op        = OP_PK;
        state_nxt = st.pk_eq ? S_FIN : S_RB;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          op             = OP_OUT;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

FILE: rtl/core/sorted_table_interpolation_search.sv
// top level of the sorted key table with scan and interpolation lookup
//
// in_ channel: a word with tuser = 0 stores its key at its position (positions
// at or beyond TABLE_DEPTH are dropped); tuser = 1 looks the key up.
// out_ channel: one word per lookup, tuser = found, tdata = matching position.
// cfg_wr_en / cfg_wr_data set the number of sorted entries in use; write it
// only while no lookup is in flight.
// A lookup below LINEAR_LIMIT entries scans the key ram through its read port
// one entry per cycle. At or above LINEAR_LIMIT entries it runs interpolation
// rounds; each reads the bounds, then a bit-serial divider computes the probe
// position, which is read and compared to narrow the bounds or end the search.
// One lookup is worked at a time; the next word is taken once the result sits
// in the output register, so a stalled receiver holds only the following
// lookup at its end. Reset clears the entry count and the handshake state;
// the key ram keeps no reset value.
module sorted_table_interpolation_search
  import stis_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = 4096,
  parameter int unsigned LINEAR_LIMIT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,   // entry_position[11:0], key_value[43:12], zero pad
  input  logic             in_tuser,   // action
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,  // match_position[11:0], zero pad
  output logic             out_tuser,  // found
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  op_t              op;
  status_t          st;
  logic [POS_W-1:0] res_pos;

  stis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .st         (st),
    .op         (op)
  );

  stis_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .LINEAR_LIMIT (LINEAR_LIMIT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .st          (st),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_pos      (in_tdata[11:0]),
    .in_key      (in_tdata[43:12]),
    .res_found   (out_tuser),
    .res_pos     (res_pos)
  );

  assign out_tdata = {4'b0, res_pos};

endmodule
